### rtl/psm_pkg.sv
package psm_pkg;

	localparam int VOICE_COUNT       = 7;
	localparam int SAMPLES_PER_VOICE = 65536;

	// fixed field widths
	localparam int SMP_W = 16;
	localparam int POS_W = 17;

	// derived widths
	localparam int VIDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int STORE_D = VOICE_COUNT * SAMPLES_PER_VOICE;
	localparam int ADDR_W  = $clog2(STORE_D);
	localparam int CNT_W   = $clog2(VOICE_COUNT + 1);
	localparam int SUM_W   = SMP_W + CNT_W;

	// item kinds
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_LENGTH  = 2'd1;
	localparam logic [1:0] KIND_TRIGGER = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0] len;
		logic [POS_W-1:0] pos;
		logic             act;
	} voice_t;

	localparam int VOICE_W = $bits(voice_t);

endpackage

### rtl/polyphonic_sample_mixer_top.sv
// a load item writes the sample store directly; a length or trigger item reads, modifies and
// writes back its voice entry; a tick item walks the voices, reading one sample word per
// voice that contributes (0..7), then divides the sum in 19 restoring steps; a silent tick
// skips the divide; one item at a time
// arst_n clears control state and all voice valid bits, so every voice reads as
// inactive with position and length zero; the sample store itself is not cleared
module polyphonic_sample_mixer_top (
	input  logic        clk,
	input  logic        arst_n,
	// input item stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // voice[2:0], address[18:3], sample[34:19], length[51:35]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	// result item stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // mixed_sample[15:0], voices_mixed[18:16]
	output logic        m_axis_tuser   // any_active[0]
);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_VMOD  = 3'd1;  // voice entry read back, apply length/trigger
	localparam logic [2:0] S_TEVAL = 3'd2;  // tick: look at voice j
	localparam logic [2:0] S_TSAMP = 3'd3;  // tick: sample word of voice j is back
	localparam logic [2:0] S_FIN   = 3'd4;  // tick: sum done, start divide unless the count is zero
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;  // wait for output register

	logic [2:0] state_q;

	// input field unpacking
	logic [1:0]  in_kind;
	logic [2:0]  in_voice;
	logic [15:0] in_address;
	logic [15:0] in_sample;
	logic [16:0] in_length;

	assign in_kind    = s_axis_tuser[1:0];
	assign in_voice   = s_axis_tdata[2:0];
	assign in_address = s_axis_tdata[18:3];
	assign in_sample  = s_axis_tdata[34:19];
	assign in_length  = s_axis_tdata[51:35];

	logic accept;
	logic voice_ok;
	logic addr_ok;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign voice_ok      = 32'(in_voice) < psm_pkg::VOICE_COUNT;
	assign addr_ok       = 32'(in_address) < psm_pkg::SAMPLES_PER_VOICE;

	// latched item for the voice read-modify-write
	logic [1:0]                 kind_q;
	logic [psm_pkg::VIDX_W-1:0] vsel_q;
	logic [psm_pkg::POS_W-1:0]  len_q;

	// tick walk state
	logic [psm_pkg::VIDX_W-1:0]        j_q;
	logic signed [psm_pkg::SUM_W-1:0]  sum_q;
	logic [psm_pkg::CNT_W-1:0]         cnt_q;
	logic                              neg_q;

	// voice state memory, with one valid bit per entry so reset reads as zero
	logic [psm_pkg::VOICE_COUNT-1:0] vvalid_q;
	logic [psm_pkg::VIDX_W-1:0]      vraddr;
	logic [psm_pkg::VIDX_W-1:0]      vraddr_q;
	logic [psm_pkg::VOICE_W-1:0]     vram_rdata;
	logic                            vwe;
	logic [psm_pkg::VIDX_W-1:0]      vwaddr;
	psm_pkg::voice_t                 vwdata;
	psm_pkg::voice_t                 vcur;

	assign vcur = vvalid_q[vraddr_q] ? psm_pkg::voice_t'(vram_rdata) : '0;

	// next voice to look at during a tick
	logic [psm_pkg::VIDX_W-1:0] j_next;
	logic                       j_last;

	assign j_next = psm_pkg::VIDX_W'(32'(j_q) + 1);
	assign j_last = (32'(j_q) == psm_pkg::VOICE_COUNT - 1);

	always_comb begin
		vraddr = j_next;
		if (state_q == S_IDLE) begin
			vraddr = (in_kind == psm_pkg::KIND_TICK) ? '0 : psm_pkg::VIDX_W'(in_voice);
		end
	end

	// tick decision on the voice just read
	logic voice_ends;
	logic voice_plays;

	assign voice_ends  = vcur.act && ((vcur.pos >= vcur.len) ||
		(32'(vcur.pos) >= psm_pkg::SAMPLES_PER_VOICE));
	assign voice_plays = vcur.act && !voice_ends;

	// saturated length for set-length items
	logic [psm_pkg::POS_W-1:0] len_sat;

	assign len_sat = (32'(in_length) > psm_pkg::SAMPLES_PER_VOICE) ?
		psm_pkg::POS_W'(psm_pkg::SAMPLES_PER_VOICE) : in_length;

	always_comb begin
		vwe    = 1'b0;
		vwaddr = vsel_q;
		vwdata = vcur;
		unique case (state_q)
			S_VMOD: begin
				vwe = 1'b1;
				if (kind_q == psm_pkg::KIND_LENGTH) begin
					vwdata.len = len_q;
				end else begin
					vwdata.pos = '0;
					vwdata.act = 1'b1;
				end
			end
			S_TEVAL: begin
				vwaddr = j_q;
				if (voice_ends) begin
					vwe        = 1'b1;
					vwdata.act = 1'b0;
				end else if (voice_plays) begin
					vwe        = 1'b1;
					vwdata.pos = vcur.pos + 1'b1;
				end
			end
			default: begin
				vwe = 1'b0;
			end
		endcase
	end

	psm_ram #(
		.WIDTH (psm_pkg::VOICE_W),
		.DEPTH (psm_pkg::VOICE_COUNT)
	) u_voice_ram (
		.clk   (clk),
		.we    (vwe),
		.waddr (vwaddr),
		.wdata (vwdata),
		.raddr (vraddr),
		.rdata (vram_rdata)
	);

	// sample store: written by load items, read once per playing voice per tick
	logic                        swe;
	logic [psm_pkg::ADDR_W-1:0]  swaddr;
	logic [psm_pkg::ADDR_W-1:0]  sraddr;
	logic [psm_pkg::SMP_W-1:0]   sram_rdata;
	logic signed [psm_pkg::SMP_W-1:0] smp;

	assign swe    = accept && (in_kind == psm_pkg::KIND_LOAD) && voice_ok && addr_ok;
	assign swaddr = psm_pkg::ADDR_W'(32'(in_voice) * psm_pkg::SAMPLES_PER_VOICE
		+ 32'(in_address));
	assign sraddr = psm_pkg::ADDR_W'(32'(j_q) * psm_pkg::SAMPLES_PER_VOICE
		+ 32'(vcur.pos));
	assign smp    = sram_rdata;

	psm_ram #(
		.WIDTH (psm_pkg::SMP_W),
		.DEPTH (psm_pkg::STORE_D)
	) u_sample_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (swaddr),
		.wdata (in_sample),
		.raddr (sraddr),
		.rdata (sram_rdata)
	);

	// sum / count on magnitudes, sign put back afterwards (truncates toward zero)
	logic                       div_start;
	logic                       div_done;
	logic [psm_pkg::SUM_W-1:0]  div_mag;
	logic [psm_pkg::SUM_W-1:0]  div_quo;
	logic [psm_pkg::SUM_W-1:0]  avg;

	assign div_start = (state_q == S_FIN) && (cnt_q != '0);
	assign div_mag   = sum_q[psm_pkg::SUM_W-1] ? psm_pkg::SUM_W'(-sum_q)
		: psm_pkg::SUM_W'(sum_q);
	assign avg       = neg_q ? psm_pkg::SUM_W'(-div_quo) : div_quo;

	psm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// finished result waiting for the output register
	logic [15:0] res_q;
	logic        out_free;

	assign out_free = !m_axis_tvalid || m_axis_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			vvalid_q <= '0;
		end else begin
			if (vwe) begin
				vvalid_q[vwaddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_kind == psm_pkg::KIND_TICK) begin
							state_q <= S_TEVAL;
						end else if (voice_ok && (in_kind != psm_pkg::KIND_LOAD)) begin
							state_q <= S_VMOD;
						end
					end
				end
				S_VMOD: begin
					state_q <= S_IDLE;
				end
				S_TEVAL: begin
					if (voice_plays) begin
						state_q <= S_TSAMP;
					end else if (j_last) begin
						state_q <= S_FIN;
					end
				end
				S_TSAMP: begin
					state_q <= j_last ? S_FIN : S_TEVAL;
				end
				S_FIN: begin
					state_q <= (cnt_q != '0) ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item and walk registers, no reset needed
	always_ff @(posedge clk) begin
		vraddr_q <= vraddr;
		if (accept) begin
			kind_q <= in_kind;
			vsel_q <= psm_pkg::VIDX_W'(in_voice);
			len_q  <= len_sat;
			j_q    <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
			res_q  <= '0;
		end
		if ((state_q == S_TEVAL && !voice_plays) || state_q == S_TSAMP) begin
			j_q <= j_next;
		end
		if (state_q == S_TSAMP) begin
			sum_q <= sum_q + psm_pkg::SUM_W'(smp);
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == S_FIN) begin
			neg_q <= sum_q[psm_pkg::SUM_W-1];
		end
		if (state_q == S_DIV && div_done) begin
			res_q <= avg[15:0];
		end
	end

	// output register
	logic        mvalid_q;
	logic [15:0] mixed_q;
	logic [2:0]  nmix_q;
	logic        any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			mvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			mixed_q <= res_q;
			nmix_q  <= 3'(cnt_q);
			any_q   <= (cnt_q != '0);
		end
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = {5'b0, nmix_q, mixed_q};
	assign m_axis_tuser  = any_q;

`ifndef SYNTH
	// the walk never looks past the last voice
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEVAL || state_q == S_TSAMP) |->
			(32'(j_q) < psm_pkg::VOICE_COUNT))
		else $error("voice walk index out of range");

	// contributor count bounded by the number of voices while an item is worked on
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (32'(cnt_q) <= psm_pkg::VOICE_COUNT))
		else $error("contributor count too large");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside divide state");

	// no divide started with a zero count
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (cnt_q != '0))
		else $error("divide started with zero count");

	// a blocked result is held back, not dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && m_axis_tvalid && !m_axis_tready) |=> (state_q == S_OUT))
		else $error("result left while output register full");
`endif

endmodule

### rtl/psm_ram.sv
module psm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/psm_div.sv
module psm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [psm_pkg::SUM_W-1:0]  dividend,
	input  logic [psm_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [psm_pkg::SUM_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(psm_pkg::SUM_W + 1);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [psm_pkg::CNT_W-1:0]  div_q;
	logic [psm_pkg::CNT_W-1:0]  rem_q;
	logic [psm_pkg::SUM_W-1:0]  quo_q;
	logic [psm_pkg::CNT_W:0]    trial;
	logic [psm_pkg::CNT_W:0]    diff;
	logic                       fits;

	// one restoring step a cycle, msb first
	assign trial = {rem_q, quo_q[psm_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(psm_pkg::SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[psm_pkg::CNT_W-1:0] : trial[psm_pkg::CNT_W-1:0];
			quo_q <= {quo_q[psm_pkg::SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### dv/tb_polyphonic_sample_mixer_top.sv
module tb_polyphonic_sample_mixer_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1050;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;

	// one input item as the generator and the predictor see it
	typedef struct packed {
		logic [psm_pkg::POS_W-1:0] length;
		logic [psm_pkg::SMP_W-1:0] sample;
		logic [15:0]               address;
		logic [2:0]                voice;
		logic [1:0]                kind;
	} mixer_item_t;

	// one mixed output item
	typedef struct {
		logic [psm_pkg::SMP_W-1:0] mixed;
		logic [2:0]                voices;
		logic                      active;
	} mix_result_t;

	// playback state of all voices, the store is kept apart
	typedef struct packed {
		logic [psm_pkg::VOICE_COUNT-1:0]                     act;
		logic [psm_pkg::VOICE_COUNT-1:0][psm_pkg::POS_W-1:0] pos;
		logic [psm_pkg::VOICE_COUNT-1:0][psm_pkg::POS_W-1:0] len;
	} voice_bank_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;  // voice[2:0], address[18:3], sample[34:19], length[51:35]
	logic [1:0]  s_axis_tuser  = '0;  // kind[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // mixed_sample[15:0], voices_mixed[18:16]
	logic        m_axis_tuser;        // any_active[0]

	polyphonic_sample_mixer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// items waiting to be sent, filled once before reset is released
	mixer_item_t pending_items[$];
	// mixed samples still owed by the block, oldest first
	mix_result_t due_mixes[$];

	// generator's own view of the voices, used only to keep playback on loaded words
	voice_bank_t plan_bank = '0;
	bit          plan_loaded [int];

	// predictor state, advanced as items are accepted
	voice_bank_t                      mix_bank = '0;
	logic signed [psm_pkg::SMP_W-1:0] mix_samples [int];

	int mismatch_count = 0;
	int cycle_count = 0;

	// driver and monitor bookkeeping
	mixer_item_t in_flight;
	bit          send_offer;
	bit          send_calm = 1'b0;
	int          send_gap = 0;
	bit          recv_take;
	bit          recv_calm = 1'b0;
	int          recv_gap = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// a voice adds a word on the next tick only while it is active and short of its length
	function automatic bit voice_sounds(voice_bank_t b, int j);
		return b.act[j] && (b.pos[j] < b.len[j]);
	endfunction

	// one tick of position bookkeeping: sounding voices step, finished ones go quiet
	function automatic void advance_bank(inout voice_bank_t b);
		for (int j = 0; j < psm_pkg::VOICE_COUNT; j++) begin
			if (b.act[j]) begin
				if (voice_sounds(b, j))
					b.pos[j] = b.pos[j] + 1'b1;
				else
					b.act[j] = 1'b0;
			end
		end
	endfunction

	// length and trigger items; out-of-range voices change nothing
	function automatic void apply_control(inout voice_bank_t b, input mixer_item_t it);
		if (it.voice >= psm_pkg::VOICE_COUNT)
			return;
		if (it.kind == psm_pkg::KIND_LENGTH) begin
			// oversized lengths saturate at the voice memory size
			b.len[it.voice] = (it.length > psm_pkg::SAMPLES_PER_VOICE) ?
				psm_pkg::POS_W'(psm_pkg::SAMPLES_PER_VOICE) : it.length;
		end else if (it.kind == psm_pkg::KIND_TRIGGER) begin
			// trigger or retrigger restarts from the first word
			b.pos[it.voice] = '0;
			b.act[it.voice] = 1'b1;
		end
	endfunction

	function automatic int store_index(int v, int a);
		return v * psm_pkg::SAMPLES_PER_VOICE + a;
	endfunction

	function automatic logic [psm_pkg::SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return psm_pkg::SMP_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// every field random so unused ones toggle too
	function automatic mixer_item_t rand_item(logic [1:0] kind);
		mixer_item_t it;
		it.kind    = kind;
		it.voice   = 3'($urandom_range(0, 7));
		it.address = 16'($urandom_range(0, 65535));
		it.sample  = rand_sample();
		it.length  = psm_pkg::POS_W'($urandom_range(0, 131071));
		return it;
	endfunction

	function automatic void enqueue(mixer_item_t it);
		pending_items.push_back(it);
		if (it.kind == psm_pkg::KIND_TICK)
			advance_bank(plan_bank);
		else if (it.kind == psm_pkg::KIND_LOAD) begin
			if (it.voice < psm_pkg::VOICE_COUNT)
				plan_loaded[store_index(it.voice, it.address)] = 1'b1;
		end else
			apply_control(plan_bank, it);
	endfunction

	// a tick preceded by loads of any word it would otherwise play unwritten
	function automatic void queue_tick();
		mixer_item_t it;
		for (int j = 0; j < psm_pkg::VOICE_COUNT; j++) begin
			if (voice_sounds(plan_bank, j) &&
				!plan_loaded.exists(store_index(j, plan_bank.pos[j]))) begin
				it = rand_item(psm_pkg::KIND_LOAD);
				it.voice = 3'(j);
				it.address = plan_bank.pos[j][15:0];
				enqueue(it);
			end
		end
		enqueue(rand_item(psm_pkg::KIND_TICK));
	endfunction

	// predictor: state change for every accepted item, a mixed sample for each tick
	function automatic void predict_item(mixer_item_t it);
		int          total;
		int          count;
		int          avg;
		mix_result_t r;
		if (it.kind == psm_pkg::KIND_TICK) begin
			total = 0;
			count = 0;
			for (int j = 0; j < psm_pkg::VOICE_COUNT; j++) begin
				if (voice_sounds(mix_bank, j)) begin
					total += mix_samples[store_index(j, mix_bank.pos[j])];
					count++;
				end
			end
			advance_bank(mix_bank);
			// int division truncates toward zero, silence gives all zero
			avg = (count > 0) ? total / count : 0;
			r.mixed  = avg[psm_pkg::SMP_W-1:0];
			r.voices = 3'(count);
			r.active = (count > 0);
			due_mixes.push_back(r);
		end else if (it.kind == psm_pkg::KIND_LOAD) begin
			if (it.voice < psm_pkg::VOICE_COUNT)
				mix_samples[store_index(it.voice, it.address)] = it.sample;
		end else
			apply_control(mix_bank, it);
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// input driver: one item offered at a time, random gap after each accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			send_offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_item(in_flight);
				send_offer = 1'b0;
				// occasionally switch between idle-free bursts and gappy traffic
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, 9);
			end
			if (!send_offer) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_items.size() != 0) begin
					in_flight = pending_items.pop_front();
					s_axis_tdata <= {4'b0, in_flight.length, in_flight.sample,
						in_flight.address, in_flight.voice};
					s_axis_tuser <= in_flight.kind;
					send_offer = 1'b1;
				end
			end
			s_axis_tvalid <= send_offer;
		end
	end

	// output monitor: checks each accepted item, then stalls for a random stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			recv_take = m_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_mixes.size() == 0)
					report_mismatch("mixed sample with none outstanding");
				else begin
					mix_result_t want;
					want = due_mixes.pop_front();
					if (m_axis_tdata[15:0] !== want.mixed)
						report_mismatch($sformatf("mixed_sample %0d, predicted %0d",
							$signed(m_axis_tdata[15:0]), $signed(want.mixed)));
					if (m_axis_tdata[18:16] !== want.voices)
						report_mismatch($sformatf("voices_mixed %0d, predicted %0d",
							m_axis_tdata[18:16], want.voices));
					if (m_axis_tuser !== want.active)
						report_mismatch($sformatf("any_active %b, predicted %b",
							m_axis_tuser, want.active));
				end
				recv_take = 1'b0;
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_gap = recv_calm ? 0 : $urandom_range(0, 9);
			end
			if (!recv_take) begin
				if (recv_gap > 0)
					recv_gap--;
				else
					recv_take = 1'b1;
			end
			m_axis_tready <= recv_take;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		mixer_item_t it;
		int          v;
		int          n;
		int          pick;

		arst_n = 1'b0;

		// directed: silence straight after reset
		queue_tick();
		// items for the voice past the last one are dropped
		for (int k = 0; k < 3; k++) begin
			it = rand_item(2'(k));
			it.voice = 3'd7;
			enqueue(it);
		end
		// all voices at the negative extreme, voice 0 with an oversized length
		for (int j = 0; j < psm_pkg::VOICE_COUNT; j++) begin
			it = rand_item(psm_pkg::KIND_LOAD);
			it.voice = 3'(j);
			it.address = '0;
			it.sample = 16'h8000;
			enqueue(it);
			it = rand_item(psm_pkg::KIND_LENGTH);
			it.voice = 3'(j);
			it.length = (j == 0) ? 17'h1ffff : 17'd1;
			enqueue(it);
			it = rand_item(psm_pkg::KIND_TRIGGER);
			it.voice = 3'(j);
			enqueue(it);
		end
		queue_tick();
		// shorten voice 0 to its current position while it plays
		it = rand_item(psm_pkg::KIND_LENGTH);
		it.voice = 3'd0;
		it.length = 17'd1;
		enqueue(it);
		queue_tick();

		// random traffic, mostly load-length-trigger phrases followed by ticks
		while (pending_items.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				v = $urandom_range(0, psm_pkg::VOICE_COUNT - 1);
				n = $urandom_range(1, 12);
				for (int a = 0; a < n; a++) begin
					it = rand_item(psm_pkg::KIND_LOAD);
					it.voice = 3'(v);
					it.address = 16'(a);
					enqueue(it);
				end
				it = rand_item(psm_pkg::KIND_LENGTH);
				it.voice = 3'(v);
				case ($urandom_range(0, 9))
					0: it.length = '0;
					1: it.length = 17'd65536;
					2: it.length = 17'h1ffff;
					3: ;  // keep the random length
					4: it.length = psm_pkg::POS_W'(n + $urandom_range(1, 20));
					default: it.length = psm_pkg::POS_W'(n);
				endcase
				enqueue(it);
				it = rand_item(psm_pkg::KIND_TRIGGER);
				it.voice = 3'(v);
				enqueue(it);
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 8)) queue_tick();
			end else if (pick < 85) begin
				// length change, often below where the voice has got to
				it = rand_item(psm_pkg::KIND_LENGTH);
				it.voice = 3'($urandom_range(0, psm_pkg::VOICE_COUNT - 1));
				if ($urandom_range(0, 3) != 0)
					it.length = psm_pkg::POS_W'($urandom_range(0, 8));
				enqueue(it);
			end else if (pick < 91) begin
				it = rand_item(psm_pkg::KIND_TRIGGER);
				it.voice = 3'($urandom_range(0, psm_pkg::VOICE_COUNT - 1));
				enqueue(it);
			end else if (pick < 96) begin
				// load anywhere in the voice memory
				it = rand_item(psm_pkg::KIND_LOAD);
				it.voice = 3'($urandom_range(0, psm_pkg::VOICE_COUNT - 1));
				enqueue(it);
			end else begin
				it = rand_item(2'($urandom_range(0, 2)));
				it.voice = 3'd7;
				enqueue(it);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all items sent and every mixed sample back, then let the block settle
		while (pending_items.size() != 0 || s_axis_tvalid || due_mixes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (due_mixes.size() != 0)
			report_mismatch($sformatf("%0d mixed samples never came out", due_mixes.size()));

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### polyphonic_sample_mixer_top.f
rtl/psm_pkg.sv
rtl/psm_ram.sv
rtl/psm_div.sv
rtl/polyphonic_sample_mixer_top.sv
dv/tb_polyphonic_sample_mixer_top.sv
